[rtl/core/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the source text stripper: payload structs,
// strip mode encoding, end status codes and the include keyword.
// ----------------------------------------------------------------------------
package sts_pkg;

  // input transaction payload
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_t;

  // output transaction payload
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       run_end;
    logic       stream_end;
    logic [1:0] end_status;
  } out_t;

  // strip mode of the front end
  typedef enum logic [1:0] {
    MODE_TEXT    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_INCLUDE = 2'd2
  } mode_t;

  // end status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_COMMENT = 2'd1;
  localparam logic [1:0] STATUS_INCLUDE = 2'd2;

  // special characters
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_SEMI  = 8'h3b;  // ';'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // keyword length and index of its last byte
  localparam int unsigned KW_LEN = 9;
  localparam logic [3:0]  KW_LAST_IDX = 4'(KW_LEN - 1);

  // work item handed from front to back: a run of keyword prefix bytes,
  // an optional trailing byte, and end of stream information
  typedef struct packed {
    logic [3:0] flush_cnt;
    logic       tail_valid;
    logic [7:0] tail_char;
    logic       last;
    logic [1:0] status;
  } desc_t;

  // bytes of the include keyword "justget::"
  function automatic logic [7:0] kw_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h6a;  // j
      4'd1:    b = 8'h75;  // u
      4'd2:    b = 8'h73;  // s
      4'd3:    b = 8'h74;  // t
      4'd4:    b = 8'h67;  // g
      4'd5:    b = 8'h65;  // e
      4'd6:    b = 8'h74;  // t
      4'd7:    b = 8'h3a;  // :
      4'd8:    b = 8'h3a;  // :
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/sts_front.sv]
// ----------------------------------------------------------------------------
// sts_front
// Accepts one byte per cycle while the queue has room, tracks comment/include
// mode and the keyword match, and queues work items for the back end.
// ----------------------------------------------------------------------------
module sts_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sts_pkg::in_t   in_data,
  input  logic           q_full,
  output logic           push,
  output sts_pkg::desc_t push_desc
);

  sts_pkg::mode_t mode, mode_next;
  logic [3:0]     matched, matched_next;
  logic           accept;
  logic           do_fresh;
  logic           fresh_j;
  logic [7:0]     c;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == sts_pkg::CH_SPACE) ||
           ((ch >= sts_pkg::CH_TAB) && (ch <= sts_pkg::CH_CR));
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c        = in_data.in_char;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= sts_pkg::MODE_TEXT;
      matched <= 4'd0;
    end else begin
      mode    <= mode_next;
      matched <= matched_next;
    end
  end

  // next state and work item
  always_comb begin
    mode_next    = mode;
    matched_next = matched;
    push_desc    = '0;
    do_fresh     = 1'b0;
    fresh_j      = 1'b0;
    push         = 1'b0;
    if (accept) begin
      case (mode)
        sts_pkg::MODE_COMMENT, sts_pkg::MODE_INCLUDE: begin
          if (c == sts_pkg::CH_SEMI) begin
            mode_next = sts_pkg::MODE_TEXT;
          end
        end
        default: begin
          if (matched != 4'd0) begin
            if (c == sts_pkg::kw_byte(matched)) begin
              if (matched == sts_pkg::KW_LAST_IDX) begin
                matched_next = 4'd0;
                mode_next    = sts_pkg::MODE_INCLUDE;
              end else begin
                matched_next = matched + 4'd1;
              end
            end else begin
              // mismatch: release the held prefix, then retry the byte
              push_desc.flush_cnt = matched;
              matched_next        = 4'd0;
              do_fresh            = 1'b1;
            end
          end else begin
            do_fresh = 1'b1;
          end
        end
      endcase

      // byte in plain text with no match in progress
      if (do_fresh) begin
        if (is_ws(c)) begin
          // dropped
        end else if (c == sts_pkg::CH_HASH) begin
          mode_next = sts_pkg::MODE_COMMENT;
        end else if (c == sts_pkg::kw_byte(4'd0)) begin
          matched_next = 4'd1;
          fresh_j      = 1'b1;
        end else begin
          push_desc.tail_valid = 1'b1;
          push_desc.tail_char  = c;
        end
      end

      // end of stream: release any partial match and report status
      if (in_data.in_last) begin
        if (fresh_j) begin
          push_desc.tail_valid = 1'b1;
          push_desc.tail_char  = sts_pkg::kw_byte(4'd0);
        end else if (matched_next != 4'd0) begin
          push_desc.flush_cnt = matched_next;
        end
        case (mode_next)
          sts_pkg::MODE_COMMENT: push_desc.status = sts_pkg::STATUS_COMMENT;
          sts_pkg::MODE_INCLUDE: push_desc.status = sts_pkg::STATUS_INCLUDE;
          default:               push_desc.status = sts_pkg::STATUS_OK;
        endcase
        push_desc.last = 1'b1;
        mode_next      = sts_pkg::MODE_TEXT;
        matched_next   = 4'd0;
      end

      push = (push_desc.flush_cnt != 4'd0) || push_desc.tail_valid || push_desc.last;
    end
  end

endmodule

[rtl/core/sts_queue.sv]
// ----------------------------------------------------------------------------
// sts_queue
// Small first-in first-out buffer of work items between front and back end.
// ----------------------------------------------------------------------------
module sts_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sts_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sts_pkg::desc_t head_desc
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  sts_pkg::desc_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign full       = (count == CNT_MAX);
  assign head_valid = (count != '0);
  assign head_desc  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/sts_back.sv]
// ----------------------------------------------------------------------------
// sts_back
// Expands each work item into its output transactions, one per cycle, into
// an output register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module sts_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  sts_pkg::desc_t head_desc,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output sts_pkg::out_t  out_data
);

  logic [3:0]    idx;
  logic [3:0]    total;
  logic [3:0]    n_eff;
  logic          is_final;
  logic          load;
  logic          fire;
  sts_pkg::out_t res;

  assign load = !out_valid || !out_stall;
  assign fire = head_valid && load;
  assign pop  = fire && is_final;

  // result for the current position within the work item
  always_comb begin
    total    = head_desc.flush_cnt + {3'b000, head_desc.tail_valid};
    n_eff    = (total == 4'd0) ? 4'd1 : total;
    is_final = ((idx + 4'd1) == n_eff);
    res      = '0;
    if (idx < head_desc.flush_cnt) begin
      res.out_char  = sts_pkg::kw_byte(idx);
      res.out_valid = 1'b1;
    end else if (head_desc.tail_valid) begin
      res.out_char  = head_desc.tail_char;
      res.out_valid = 1'b1;
    end
    res.run_end    = is_final;
    res.stream_end = is_final && head_desc.last;
    res.end_status = (is_final && head_desc.last) ? head_desc.status : sts_pkg::STATUS_OK;
  end

  // position counter within the work item
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 4'd0;
    end else if (fire) begin
      idx <= is_final ? 4'd0 : idx + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

endmodule

[rtl/core/source_text_stripper.sv]
// ----------------------------------------------------------------------------
// source_text_stripper
// Byte stream filter that drops whitespace, '#'...';' comments and include
// statements that open with the keyword "justget::" and close at ';'.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------
//   in      | input     | in_valid / in_stall  | in_data  (sts_pkg::in_t)
//   out     | output    | out_valid / out_stall| out_data (sts_pkg::out_t)
//
// One byte is accepted per cycle while the work queue has room.
// Each byte yields 0 to 9 output transactions, emitted one per cycle by the
// back end while the output is not stalled; a byte that releases a held
// keyword prefix of k bytes yields k transactions, plus one when the byte
// itself is kept, so plain text flows at one byte per cycle without stalls.
// The first transaction of a byte is written to the work queue and from there
// into the output register.
// Reset (rst, synchronous) returns to plain text mode with an empty queue.
// Output stall holds the output register; input stalls only on a full queue.
// ----------------------------------------------------------------------------
module source_text_stripper #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sts_pkg::out_t out_data
);

  logic           q_full;
  logic           push;
  sts_pkg::desc_t push_desc;
  logic           pop;
  logic           head_valid;
  sts_pkg::desc_t head_desc;

  // classification front end
  sts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  // work queue
  sts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  // output back end
  sts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[rtl/core/sts_checker.sv]
// ----------------------------------------------------------------------------
// sts_checker
// Port level checks on the output channel of the source text stripper.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input sts_pkg::out_t out_data
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // end status only on the stream end transaction
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.stream_end |-> out_data.end_status == sts_pkg::STATUS_OK)
    else $error("end status outside stream end");

  // stream end closes its run
  a_stream_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stream_end |-> out_data.run_end)
    else $error("stream end without run end");

  // empty transaction only as a lone stream end marker
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.out_valid |->
      out_data.stream_end && out_data.out_char == 8'h00)
    else $error("empty transaction outside stream end");

  // status code in range
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.end_status != 2'd3)
    else $error("bad end status code");

endmodule

bind source_text_stripper sts_checker u_sts_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
